// ===== rtl/rmtp_pkg.sv =====
// Shared constants and types for the range maximum triangle perimeter block.
// Used by rmtp_rank_list and range_max_triangle_perimeter; no dependencies.
`default_nettype none
package rmtp_pkg;
	localparam int MAX_ITEMS = 1024;
	localparam int TOP_RANKS = 50;
	localparam int VAL_W = 31;
	localparam int IDX_W = 11;
	localparam int PERIM_W = 33;
	localparam int ADDR_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int KEPT_W = $clog2(TOP_RANKS + 1);

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	typedef logic [VAL_W-1:0] val_t;

	typedef struct packed {
		logic              start;
		logic [KEPT_W-1:0] limit;
		logic              insert;
		val_t              ins_val;
		logic              pop;
	} rank_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/range_max_triangle_perimeter.sv =====
// Top level: value store, range scan into the rank list, triangle check.
// Depends on rmtp_pkg, rmtp_ram and rmtp_rank_list.
//
//   channel | signals                                        | direction
//   input   | in_valid, in_stall, req_type, value,          | into block
//           | range_left, range_right                        |
//   output  | out_valid, out_stall, found, perimeter         | out of block
//
// A query with a valid range scans its range through the value RAM (one
// read per cycle, registered read), then runs triangle checks, then posts
// the result. Reset empties the list with no clearing pass.
// A query waits in its final state while an earlier result is stalled.
`default_nettype none
module range_max_triangle_perimeter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   req_type,
	input  wire logic [rmtp_pkg::VAL_W-1:0]   value,
	input  wire logic [rmtp_pkg::IDX_W-1:0]   range_left,
	input  wire logic [rmtp_pkg::IDX_W-1:0]   range_right,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              found,
	output logic [rmtp_pkg::PERIM_W-1:0]      perimeter
);
	import rmtp_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [ADDR_W-1:0]  end_q;
	logic               issue_done_q;
	logic               rd_vld_s1;
	logic               rd_last_s1;
	logic               res_found_q;
	logic [PERIM_W-1:0] res_perim_q;
	logic               out_valid_q;
	logic               found_q;
	logic [PERIM_W-1:0] perim_q;

	logic               in_xfer;
	logic               out_free;
	logic               issuing;
	logic               bad_range;
	logic [IDX_W-1:0]   len;
	logic [KEPT_W-1:0]  limit;
	logic               append_ok;
	val_t               rd_data;
	rank_ctrl_t         rctrl;
	logic [KEPT_W-1:0]  kept;
	val_t               top0, top1, top2;
	logic [VAL_W:0]     bc_sum;
	logic [PERIM_W-1:0] abc_sum;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign issuing = (state_q == ST_SCAN) && !issue_done_q;
	assign append_ok = (count_q < CNT_W'(MAX_ITEMS));

	assign len = range_right - range_left + IDX_W'(1);
	assign bad_range = (range_left == '0) || (range_left > range_right)
		|| (CNT_W'(range_right) > count_q) || (len < IDX_W'(3));
	assign limit = (len < IDX_W'(TOP_RANKS)) ? KEPT_W'(len) : KEPT_W'(TOP_RANKS);

	rmtp_ram #(.W(VAL_W), .D(MAX_ITEMS)) u_store (
		.clk  (clk),
		.we   (in_xfer && req_type == REQ_APPEND && append_ok),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(value),
		.re   (issuing),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	assign bc_sum = {1'b0, top1} + {1'b0, top2};
	assign abc_sum = {2'b00, top0} + {1'b0, bc_sum};

	always_comb begin
		rctrl.start = in_xfer && req_type == REQ_QUERY && !bad_range;
		rctrl.limit = limit;
		rctrl.insert = rd_vld_s1;
		rctrl.ins_val = rd_data;
		rctrl.pop = (state_q == ST_CHECK) && (kept >= KEPT_W'(3))
			&& !(bc_sum > {1'b0, top0});
	end

	rmtp_rank_list u_rank (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (rctrl),
		.kept  (kept),
		.top0  (top0),
		.top1  (top1),
		.top2  (top2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issuing;
			rd_last_s1 <= issuing && (idx_q == end_q);
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (req_type)
							REQ_CLEAR: count_q <= '0;
							REQ_APPEND: begin
								if (append_ok)
									count_q <= count_q + CNT_W'(1);
							end
							REQ_QUERY: begin
								issue_done_q <= 1'b0;
								state_q <= bad_range ? ST_DONE : ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (issuing && idx_q == end_q)
						issue_done_q <= 1'b1;
					if (rd_last_s1)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (kept < KEPT_W'(3) || bc_sum > {1'b0, top0})
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers: scan window and result
	always_ff @(posedge clk) begin
		if (in_xfer && req_type == REQ_QUERY) begin
			idx_q <= ADDR_W'(range_left - IDX_W'(1));
			end_q <= ADDR_W'(range_right - IDX_W'(1));
			res_found_q <= 1'b0;
			res_perim_q <= '0;
		end else if (issuing) begin
			idx_q <= idx_q + ADDR_W'(1);
		end
		if (state_q == ST_CHECK && kept >= KEPT_W'(3) && bc_sum > {1'b0, top0}) begin
			res_found_q <= 1'b1;
			res_perim_q <= abc_sum;
		end
		if (state_q == ST_DONE && out_free) begin
			found_q <= res_found_q;
			perim_q <= res_perim_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign perimeter = perim_q;

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == ST_SCAN)
		else $error("value read returned outside the scan");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result posted outside the final state");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("item count past capacity");
endmodule
`default_nettype wire

// ===== rtl/rmtp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module rmtp_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/rmtp_rank_list.sv =====
// Sorted list of the largest values seen in a range scan, descending order.
// Depends on rmtp_pkg.
`default_nettype none
module rmtp_rank_list (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rmtp_pkg::rank_ctrl_t        ctrl,
	output logic [rmtp_pkg::KEPT_W-1:0]      kept,
	output rmtp_pkg::val_t                   top0,
	output rmtp_pkg::val_t                   top1,
	output rmtp_pkg::val_t                   top2
);
	import rmtp_pkg::*;

	val_t              slot_q [TOP_RANKS];
	val_t              slot_nxt [TOP_RANKS];
	logic [KEPT_W-1:0] kept_q;
	logic [KEPT_W-1:0] limit_q;
	logic              full;
	logic              skip;

	assign full = (kept_q == limit_q);
	assign skip = full && (ctrl.ins_val <= slot_q[kept_q - KEPT_W'(1)]);

	always_comb begin
		for (int j = 0; j < TOP_RANKS; j++) begin
			if (KEPT_W'(j) < kept_q && slot_q[j] >= ctrl.ins_val)
				slot_nxt[j] = slot_q[j];
			else if (j == 0)
				slot_nxt[j] = ctrl.ins_val;
			else if (KEPT_W'(j - 1) < kept_q && slot_q[j-1] >= ctrl.ins_val)
				slot_nxt[j] = ctrl.ins_val;
			else
				slot_nxt[j] = slot_q[(j == 0) ? 0 : j - 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
			limit_q <= KEPT_W'(TOP_RANKS);
		end else if (ctrl.start) begin
			kept_q <= '0;
			limit_q <= ctrl.limit;
		end else if (ctrl.insert && !skip) begin
			if (!full)
				kept_q <= kept_q + KEPT_W'(1);
		end else if (ctrl.pop) begin
			kept_q <= kept_q - KEPT_W'(1);
		end
	end

	// insert into the sorted slots, or advance the window down one rank on pop
	always_ff @(posedge clk) begin
		if (ctrl.insert && !skip) begin
			for (int j = 0; j < TOP_RANKS; j++)
				slot_q[j] <= slot_nxt[j];
		end else if (ctrl.pop) begin
			for (int j = 0; j < TOP_RANKS - 1; j++)
				slot_q[j] <= slot_q[j+1];
		end
	end

	assign kept = kept_q;
	assign top0 = slot_q[0];
	assign top1 = slot_q[1];
	assign top2 = slot_q[2];

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= limit_q)
		else $error("rank list holds more than its limit");
	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> kept_q == '0)
		else $error("rank list not emptied on start");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> kept_q != '0)
		else $error("pop from empty rank list");
endmodule
`default_nettype wire

// ===== sim/range_max_triangle_perimeter_tb.sv =====
// Testbench for range_max_triangle_perimeter: directed and random clear,
// append and query transfers, checked against an in-bench triangle predictor.
// Depends on rmtp_pkg and the range_max_triangle_perimeter RTL.
`default_nettype none
module range_max_triangle_perimeter_tb;
	import rmtp_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic                found;
		logic [PERIM_W-1:0]  perimeter;
	} triangle_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = REQ_CLEAR;
	logic [VAL_W-1:0] value = '0;
	logic [IDX_W-1:0] range_left = '0;
	logic [IDX_W-1:0] range_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic found;
	logic [PERIM_W-1:0] perimeter;

	val_t stored_values [MAX_ITEMS];
	int unsigned list_len = 0;
	triangle_t expected_triangles [$];
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_off_cycles = 0;

	always #5 clk = ~clk;

	range_max_triangle_perimeter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .value(value),
		.range_left(range_left), .range_right(range_right),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .perimeter(perimeter)
	);

	function automatic triangle_t predict_triangle(int unsigned lo, int unsigned hi);
		triangle_t r;
		val_t top [TOP_RANKS];
		int kept;
		int lim;
		int pos;
		val_t v;
		logic [PERIM_W-1:0] a, b, c;
		r = '0;
		kept = 0;
		if (lo == 0 || lo > hi || hi > list_len || hi - lo + 1 < 3)
			return r;
		lim = (hi - lo + 1 < TOP_RANKS) ? hi - lo + 1 : TOP_RANKS;
		for (int k = lo - 1; k < hi; k++) begin
			v = stored_values[k];
			if (kept == lim) begin
				if (v <= top[kept - 1])
					continue;
				kept--;
			end
			pos = kept;
			while (pos > 0 && top[pos - 1] < v) begin
				top[pos] = top[pos - 1];
				pos--;
			end
			top[pos] = v;
			kept++;
		end
		for (int i = 0; i + 2 < kept; i++) begin
			a = {2'b00, top[i]};
			b = {2'b00, top[i + 1]};
			c = {2'b00, top[i + 2]};
			if (b + c > a) begin
				r.found = 1'b1;
				r.perimeter = a + b + c;
				return r;
			end
		end
		return r;
	endfunction

	// Drive one transfer, then update the predicted list once it is taken.
	task automatic send_request(logic [1:0] kind, val_t v, int unsigned lo, int unsigned hi);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		value <= v;
		range_left <= lo[IDX_W-1:0];
		range_right <= hi[IDX_W-1:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		case (kind)
			REQ_CLEAR: list_len = 0;
			REQ_APPEND: if (list_len < MAX_ITEMS) begin
				stored_values[list_len] = v;
				list_len++;
			end
			REQ_QUERY: expected_triangles.push_back(predict_triangle(lo, hi));
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_triangles.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			out_stall <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		triangle_t exp_t;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_triangles.size() == 0) begin
				$display("%0t: unexpected result found=%0b perimeter=%0d",
					$time, found, perimeter);
				errors++;
			end else begin
				exp_t = expected_triangles.pop_front();
				if (found !== exp_t.found) begin
					$display("%0t: found expected %0b actual %0b", $time, exp_t.found, found);
					errors++;
				end
				if (perimeter !== exp_t.perimeter) begin
					$display("%0t: perimeter expected %0d actual %0d",
						$time, exp_t.perimeter, perimeter);
					errors++;
				end
			end
		end
	end

	function automatic val_t rand_value();
		case ($urandom_range(3))
			0: return val_t'($urandom_range(20));
			1: return val_t'($urandom_range(1000));
			2: return val_t'($urandom);
			default: return 31'h7FFF_FFFF - val_t'($urandom_range(5));
		endcase
	endfunction

	task automatic test_directed();
		send_request(REQ_QUERY, '0, 1, 3);
		send_request(REQ_APPEND, 31'h7FFF_FFFF, 0, 0);
		send_request(REQ_APPEND, 31'h7FFF_FFFF, 0, 0);
		send_request(REQ_QUERY, '0, 1, 2);
		send_request(REQ_APPEND, 31'h7FFF_FFFF, 0, 0);
		send_request(REQ_QUERY, '0, 1, 3);
		send_request(REQ_QUERY, '0, 0, 3);
		send_request(REQ_QUERY, '0, 3, 1);
		send_request(REQ_QUERY, '0, 1, 4);
		send_request(REQ_QUERY, '0, 2047, 2047);
		send_request(REQ_UNKNOWN, 31'h7FFF_FFFF, 2047, 2047);
		send_request(REQ_CLEAR, '0, 0, 0);
		// fibonacci-like sequence: no triangle until 4 is appended
		send_request(REQ_APPEND, 31'd1, 0, 0);
		send_request(REQ_APPEND, 31'd2, 0, 0);
		send_request(REQ_APPEND, 31'd3, 0, 0);
		send_request(REQ_APPEND, 31'd5, 0, 0);
		send_request(REQ_APPEND, 31'd0, 0, 0);
		send_request(REQ_QUERY, '0, 1, 5);
		send_request(REQ_APPEND, 31'd4, 0, 0);
		send_request(REQ_QUERY, '0, 1, 6);
		wait_drained();
	endtask

	task automatic test_full_list();
		send_request(REQ_CLEAR, '0, 0, 0);
		for (int i = 0; i < MAX_ITEMS + 2; i++)
			send_request(REQ_APPEND, rand_value(), 0, 0);
		send_request(REQ_QUERY, '0, 1, MAX_ITEMS);
		send_request(REQ_QUERY, '0, MAX_ITEMS - 2, MAX_ITEMS);
		send_request(REQ_QUERY, '0, 1, MAX_ITEMS + 1);
		wait_drained();
	endtask

	task automatic test_random(int n);
		int unsigned lo, hi;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0: send_request(REQ_CLEAR, rand_value(), $urandom_range(2047),
					$urandom_range(2047));
				1: send_request(REQ_UNKNOWN, rand_value(), $urandom_range(2047),
					$urandom_range(2047));
				2, 3, 4, 5, 6, 7, 8, 9: send_request(REQ_APPEND, rand_value(), 0, 0);
				18: send_request(REQ_QUERY, rand_value(), $urandom_range(2047),
					$urandom_range(2047));
				default: begin
					if (list_len == 0) begin
						lo = 1;
						hi = 1;
					end else begin
						hi = $urandom_range(list_len, 1);
						lo = $urandom_range(hi, (hi > 60) ? hi - 60 : 1);
					end
					send_request(REQ_QUERY, rand_value(), lo, hi);
				end
			endcase
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_off_cycles = 3000;
		for (int i = 0; i < 20; i++)
			send_request(REQ_QUERY, '0, 1, (list_len < 3) ? 3 : list_len);
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(30);
		send_idle_pct = 85;
		test_random(25);
		send_idle_pct = 0;
		stall_pct = 85;
		test_random(25);
		send_idle_pct = 19;
		stall_pct = 19;
		test_full_list();
		send_idle_pct = 0;
		stall_pct = 0;
		test_backpressure();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#100000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
